### design/law_pkg.sv
// Shared types and constants for the landmark association weight block.
package law_pkg;

    localparam int unsigned IdW  = 16;
    localparam int unsigned PosW = 32;
    localparam int unsigned AngW = 16;
    localparam int unsigned WsW  = 48;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_INV_VAR_X = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_INV_VAR_Y = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LOG_NORM  = 2'd2;

    localparam logic signed [63:0] C1 = 64'sd1686629713;
    localparam logic signed [63:0] C3 = 64'sd693598668;
    localparam logic signed [63:0] C5 = 64'sd85569306;
    localparam logic signed [63:0] C7 = 64'sd5026995;
    localparam logic signed [63:0] C9 = 64'sd172272;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic [47:0] TERM_CAP = 48'h8000_0000_0000;

    typedef struct packed {
        logic                   kind;
        logic [IdW-1:0]         landmark_id;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] particle_x;
        logic signed [PosW-1:0] particle_y;
        logic [AngW-1:0]        particle_heading;
        logic                   last_observation;
    } t_in_word;

    typedef struct packed {
        logic [IdW-1:0]         matched_id;
        logic signed [PosW-1:0] matched_x;
        logic signed [PosW-1:0] matched_y;
        logic signed [WsW-1:0]  neg_log_weight;
        logic                   weight_final;
        logic                   status;
    } t_out_word;

    // Queue entry between front and back: map-frame observation or load.
    typedef struct packed {
        logic                   kind;
        logic [IdW-1:0]         landmark_id;
        logic signed [PosW-1:0] x;
        logic signed [PosW-1:0] y;
        logic                   last_observation;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE, FS_POLY, FS_ROT_MUL, FS_ROT_SUM, FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE, BS_SCAN, BS_DRAIN, BS_TERM, BS_SUM, BS_OUT
    } t_back_state;

    function automatic logic signed [63:0] mul_q30(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] m;
        logic signed [63:0] r;
        neg = a[63] ^ b[63];
        ma  = a[63] ? 32'(-a) : 32'(a);
        mb  = b[63] ? 32'(-b) : 32'(b);
        m   = 64'(ma) * 64'(mb);
        r   = $signed(m >> 30);
        return neg ? -r : r;
    endfunction

endpackage

### design/law_if.sv
// Valid/ready channel carrying one word of type T.
interface law_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/landmark_association_weight_top.sv
// Top level of the landmark association and particle weight block.
//
//  channel | dir | word        | accepted when
//  in_ch   | in  | t_in_word   | valid && ready
//  out_ch  | out | t_out_word  | valid && ready
//  cfg     | in  | index,data  | i_cfg_we
//
// A load word holds the front through accept and push, and the back for its pop.
// An observation holds the front through accept, six polynomial steps, rotate
// multiply, rotate sum and push, and the back through pop, a scan of one table
// entry per cycle, the drain of the distance pipeline, term, sum and result;
// on an empty table the back skips scan, drain and term. Front and back overlap
// through a two-entry queue.
// Reset is synchronous active low; it empties the table and clears the sum.
// A stalled result holds its word; the front keeps working until the queue fills.
module landmark_association_weight_top #(
    parameter int unsigned MAX_LANDMARKS   = 64,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    law_if.sink                         in_ch,
    law_if.source                       out_ch,
    input  logic                        i_cfg_we,
    input  logic [law_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import law_pkg::*;

    logic [31:0] r_inv_var_x, r_inv_var_y;
    logic signed [31:0] r_log_norm;
    logic w_push, w_full, w_pop, w_empty;
    t_job w_fjob, w_qjob;

    // Register writes; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_var_x <= 32'd65536;
            r_inv_var_y <= 32'd65536;
            r_log_norm  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INV_VAR_X: r_inv_var_x <= i_cfg_data;
                CFG_INV_VAR_Y: r_inv_var_y <= i_cfg_data;
                CFG_LOG_NORM:  r_log_norm  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    law_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_push(w_push), .o_job(w_fjob), .i_full(w_full)
    );

    law_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_job(w_fjob), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_qjob)
    );

    law_back #(.MAX_LANDMARKS(MAX_LANDMARKS)) u_back (
        .i_clk, .i_rst_n,
        .i_empty(w_empty), .i_job(w_qjob), .o_pop(w_pop),
        .i_inv_var_x(r_inv_var_x), .i_inv_var_y(r_inv_var_y),
        .i_log_norm(r_log_norm), .out_ch
    );
endmodule

### design/law_front.sv
// Front: takes words, computes sine/cosine and map-frame observation.
module law_front #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    law_if.sink                in_ch,
    output logic               o_push,
    output law_pkg::t_job      o_job,
    input  logic               i_full
);
    import law_pkg::*;

    localparam int unsigned Sh = 16 - SINE_TABLE_BITS;

    t_front_state r_st, n_st;
    t_in_word     r_in;
    logic [2:0]   r_step, n_step;
    logic signed [63:0] r_xs, r_xc, r_x2s, r_x2c, r_ps, r_pc;
    logic [1:0]   r_qs, r_qc;
    logic signed [31:0] r_sin, r_cos;
    logic signed [63:0] r_m0, r_m1, r_m2, r_m3;
    t_job         r_job;

    logic [AngW-1:0] w_ang, w_angc;
    logic [13:0] w_ts, w_tc;
    logic signed [63:0] w_fs, w_fc;

    assign w_ang  = (r_in.particle_heading >> Sh) << Sh;
    assign w_angc = w_ang + 16'd16384;
    assign w_ts = w_ang[13:0];
    assign w_tc = w_angc[13:0];

    function automatic logic signed [63:0] fold(logic [1:0] q, logic [13:0] t);
        logic [14:0] u;
        u = q[0] ? (15'd16384 - {1'b0, t}) : {1'b0, t};
        return 64'(u) <<< 16;
    endfunction

    function automatic logic signed [63:0] coef(logic [2:0] k);
        case (k)
            3'd0:    return -C7;
            3'd1:    return C5;
            3'd2:    return -C3;
            default: return C1;
        endcase
    endfunction

    function automatic logic signed [63:0] fin(logic signed [63:0] p,
                                               logic signed [63:0] x, logic [1:0] q);
        logic signed [63:0] v;
        v = mul_q30(p, x);
        if (v < 0) v = 0;
        if (v > Q30_ONE) v = Q30_ONE;
        return q[1] ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    assign w_fs = fold(w_ang[15:14], w_ts);
    assign w_fc = fold(w_angc[15:14], w_tc);

    assign in_ch.ready = (r_st == FS_IDLE);
    assign o_push = (r_st == FS_PUSH) && !i_full;
    assign o_job  = r_job;

    always_comb begin
        n_st = r_st;
        n_step = r_step;
        case (r_st)
            FS_IDLE: if (in_ch.valid) begin
                n_st = in_ch.data.kind ? FS_POLY : FS_PUSH;
                n_step = 3'd0;
            end
            FS_POLY: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) n_st = FS_ROT_MUL;
            end
            FS_ROT_MUL: n_st = FS_ROT_SUM;
            FS_ROT_SUM: n_st = FS_PUSH;
            FS_PUSH:    if (!i_full) n_st = FS_IDLE;
            default:    n_st = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FS_IDLE;
            r_step <= 3'd0;
        end else begin
            r_st <= n_st;
            r_step <= n_step;
        end
    end

    // Polynomial: step 0 folds and squares, steps 1..4 Horner, step 5 finish.
    always_ff @(posedge i_clk) begin
        if (r_st == FS_IDLE && in_ch.valid) begin
            r_in <= in_ch.data;
            r_job.kind <= in_ch.data.kind;
            r_job.landmark_id <= in_ch.data.landmark_id;
            r_job.x <= in_ch.data.pos_x;
            r_job.y <= in_ch.data.pos_y;
            r_job.last_observation <= in_ch.data.last_observation;
        end
        if (r_st == FS_POLY) begin
            if (r_step == 3'd0) begin
                r_xs <= w_fs;
                r_xc <= w_fc;
                r_qs <= w_ang[15:14];
                r_qc <= w_angc[15:14];
                r_x2s <= mul_q30(w_fs, w_fs);
                r_x2c <= mul_q30(w_fc, w_fc);
                r_ps <= C9;
                r_pc <= C9;
            end else if (r_step == 3'd5) begin
                r_sin <= 32'(fin(r_ps, r_xs, r_qs));
                r_cos <= 32'(fin(r_pc, r_xc, r_qc));
            end else begin
                r_ps <= coef(r_step - 3'd1) + mul_q30(r_ps, r_x2s);
                r_pc <= coef(r_step - 3'd1) + mul_q30(r_pc, r_x2c);
            end
        end
        if (r_st == FS_ROT_MUL) begin
            r_m0 <= 64'(r_in.pos_x) * 64'(r_cos);
            r_m1 <= 64'(r_in.pos_y) * 64'(r_sin);
            r_m2 <= 64'(r_in.pos_x) * 64'(r_sin);
            r_m3 <= 64'(r_in.pos_y) * 64'(r_cos);
        end
        if (r_st == FS_ROT_SUM) begin
            r_job.x <= sat32(64'(r_in.particle_x) + ((r_m0 - r_m1) >>> 30));
            r_job.y <= sat32(64'(r_in.particle_y) + ((r_m2 + r_m3) >>> 30));
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_st == FS_IDLE)
        else $error("front push not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("front took two words back to back");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == FS_PUSH && i_full) |=> r_st == FS_PUSH && $stable(r_job))
        else $error("front job changed while queue full");
endmodule

### design/law_queue.sv
// Two-entry job queue between front and back.
module law_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  law_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output law_pkg::t_job o_job
);
    import law_pkg::*;

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue overflow or underflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count missed a push");
endmodule

### design/law_back.sv
// Back: landmark table, nearest scan, weight accumulation and output.
module law_back #(
    parameter int unsigned MAX_LANDMARKS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  law_pkg::t_job       i_job,
    output logic                o_pop,
    input  logic [31:0]         i_inv_var_x,
    input  logic [31:0]         i_inv_var_y,
    input  logic signed [31:0]  i_log_norm,
    law_if.source               out_ch
);
    import law_pkg::*;

    localparam int unsigned AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int unsigned CW = $clog2(MAX_LANDMARKS + 1);

    t_back_state r_st, n_st;
    logic [IdW-1:0]  r_ids [MAX_LANDMARKS];
    logic [PosW-1:0] r_xs  [MAX_LANDMARKS];
    logic [PosW-1:0] r_ys  [MAX_LANDMARKS];
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_idx;
    logic            r_rd_v, r_sq_v;
    logic [PosW-1:0] r_lx, r_ly;
    logic [IdW-1:0]  r_lid;
    logic [AW-1:0]   r_rd_i, r_sq_i;
    logic [63:0]     r_dx2, r_dy2;
    logic            r_have;
    logic [63:0]     r_bd, r_bdx2, r_bdy2;
    logic [AW-1:0]   r_bi;
    logic [47:0]     r_tx, r_ty;
    logic signed [WsW-1:0] r_ws;
    t_job            r_job;
    t_out_word       r_out;

    logic signed [32:0] w_dx, w_dy;
    logic [32:0] w_ax, w_ay;
    logic [64:0] w_d;
    logic [63:0] w_ds;
    logic [CW-1:0] w_cnt_max;

    assign w_cnt_max = CW'(MAX_LANDMARKS);

    function automatic logic [47:0] axis_term(logic [63:0] d2, logic [31:0] iv);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] hi;
        logic [64:0] lo;
        a = 64'(d2[63:32]) * 64'(iv);
        b = 64'(d2[31:0]) * 64'(iv);
        hi = a >> 1;
        lo = ((65'(a[0]) << 32) + 65'(b)) >> 33;
        if (hi >= 64'(TERM_CAP)) return TERM_CAP;
        hi = hi + lo[63:0];
        return (hi > 64'(TERM_CAP)) ? TERM_CAP : hi[47:0];
    endfunction

    assign w_dx = 33'(r_job.x) - 33'($signed(r_lx));
    assign w_dy = 33'(r_job.y) - 33'($signed(r_ly));
    assign w_ax = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ay = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
    assign w_d  = 65'(r_dx2) + 65'(r_dy2);
    assign w_ds = w_d[64] ? '1 : w_d[63:0];

    assign out_ch.valid = (r_st == BS_OUT);
    assign out_ch.data  = r_out;
    assign o_pop = (r_st == BS_IDLE) && !i_empty;

    always_comb begin
        n_st = r_st;
        case (r_st)
            BS_IDLE: if (!i_empty) begin
                if (!i_job.kind) n_st = BS_IDLE;
                else if (r_cnt == '0) n_st = BS_SUM;
                else n_st = BS_SCAN;
            end
            BS_SCAN:  if (r_idx == r_cnt - CW'(1)) n_st = BS_DRAIN;
            BS_DRAIN: if (!r_rd_v && !r_sq_v) n_st = BS_TERM;
            BS_TERM:  n_st = BS_SUM;
            BS_SUM:   n_st = BS_OUT;
            BS_OUT:   if (out_ch.ready) n_st = BS_IDLE;
            default:  n_st = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_IDLE;
            r_cnt <= '0;
            r_ws <= '0;
            r_rd_v <= 1'b0;
            r_sq_v <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_st <= n_st;
            r_rd_v <= (r_st == BS_SCAN);
            r_sq_v <= r_rd_v;
            if (o_pop && !i_job.kind && r_cnt < w_cnt_max) r_cnt <= r_cnt + CW'(1);
            if (o_pop) r_have <= 1'b0;
            if (r_sq_v) r_have <= 1'b1;
            // Take the shown sum; drop it once the closing result leaves.
            if (r_st == BS_OUT)
                r_ws <= (out_ch.ready && r_job.last_observation) ? '0
                                                                 : r_out.neg_log_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [51:0] tot;
        if (o_pop && !i_job.kind && r_cnt < w_cnt_max) begin
            r_ids[r_cnt[AW-1:0]] <= i_job.landmark_id;
            r_xs[r_cnt[AW-1:0]]  <= i_job.x;
            r_ys[r_cnt[AW-1:0]]  <= i_job.y;
        end
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= '0;
        end
        if (r_st == BS_SCAN) begin
            r_idx <= r_idx + CW'(1);
            r_rd_i <= r_idx[AW-1:0];
            r_lx <= r_xs[r_idx[AW-1:0]];
            r_ly <= r_ys[r_idx[AW-1:0]];
        end
        // Square stage.
        r_sq_i <= r_rd_i;
        r_dx2 <= 64'(w_ax) * 64'(w_ax);
        r_dy2 <= 64'(w_ay) * 64'(w_ay);
        // Compare stage: strict less keeps the first minimum.
        if (r_sq_v && (!r_have || w_ds < r_bd)) begin
            r_bd <= w_ds;
            r_bdx2 <= r_dx2;
            r_bdy2 <= r_dy2;
            r_bi <= r_sq_i;
        end
        if (r_st == BS_TERM) begin
            r_tx <= axis_term(r_bdx2, i_inv_var_x);
            r_ty <= axis_term(r_bdy2, i_inv_var_y);
            r_lid <= r_ids[r_bi];
            r_out.matched_x <= r_xs[r_bi];
            r_out.matched_y <= r_ys[r_bi];
        end
        if (r_st == BS_SUM) begin
            tot = 52'(r_ws) + 52'(r_tx) + 52'(r_ty) + 52'(i_log_norm);
            r_out.weight_final <= r_job.last_observation;
            if (r_cnt == '0) begin
                r_out.status <= 1'b1;
                r_out.matched_id <= '0;
                r_out.matched_x <= '0;
                r_out.matched_y <= '0;
                r_out.neg_log_weight <= r_ws;
            end else begin
                r_out.status <= 1'b0;
                r_out.matched_id <= r_lid;
                if (tot > 52'sh7fff_ffff_ffff) r_out.neg_log_weight <= 48'sh7fff_ffff_ffff;
                else if (tot < -52'sh8000_0000_0000)
                    r_out.neg_log_weight <= 48'sh8000_0000_0000;
                else r_out.neg_log_weight <= tot[47:0];
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= w_cnt_max)
        else $error("landmark count above table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(r_out))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == BS_TERM) |-> r_have)
        else $error("term computed without a best entry");
endmodule

### tb/tb_top.sv
// Self-checking testbench for the landmark association and particle weight block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import law_pkg::*;

    // Polynomial coefficients for the quarter-wave sine, Q30.
    localparam longint K1 = 64'sd1686629713;
    localparam longint K3 = 64'sd693598668;
    localparam longint K5 = 64'sd85569306;
    localparam longint K7 = 64'sd5026995;
    localparam longint K9 = 64'sd172272;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint SUM_MAX = 64'sd140737488355327;
    localparam longint SUM_MIN = -64'sd140737488355328;
    localparam longint unsigned AXIS_CAP = 64'd140737488355328;
    localparam int TABLE_DEPTH = 64;
    localparam int ANGLE_DROP = 16 - 10;
    localparam int LONG_HOLD = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    law_if #(.T(t_in_word))  in_ch (i_clk);
    law_if #(.T(t_out_word)) out_ch (i_clk);

    landmark_association_weight_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: a mirror of the landmark table, the running sum and the registers.
    logic [15:0] lm_id [TABLE_DEPTH];
    logic [31:0] lm_x  [TABLE_DEPTH];
    logic [31:0] lm_y  [TABLE_DEPTH];
    int          lm_count;
    longint      weight_acc;
    logic [31:0] inv_var_x_reg;
    logic [31:0] inv_var_y_reg;
    logic [31:0] log_norm_reg;

    t_out_word pending_results[$];
    int        mismatch_count;
    bit        quiet;
    int        hold_reqs;
    int        hold_served;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Q30 product truncated toward zero.
    function automatic longint q30_prod(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r  = longint'((ma * mb) >> 30);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Sine over one quarter turn, t in 0..16384, Q30, clamped to [0, 1].
    function automatic longint quarter_sine(int t);
        longint x;
        longint x2;
        longint p;
        x  = longint'(t) <<< 16;
        x2 = q30_prod(x, x);
        p  = K9;
        p  = -K7 + q30_prod(p, x2);
        p  =  K5 + q30_prod(p, x2);
        p  = -K3 + q30_prod(p, x2);
        p  =  K1 + q30_prod(p, x2);
        p  = q30_prod(p, x);
        if (p < 0) p = 0;
        if (p > ONE_Q30) p = ONE_Q30;
        return p;
    endfunction

    function automatic longint turn_sine(logic [15:0] a);
        longint s;
        int t;
        t = int'(a[13:0]);
        s = a[14] ? quarter_sine(16384 - t) : quarter_sine(t);
        return a[15] ? -s : s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(d2 * iv / 2^33), capped at 2^47.
    function automatic longint unsigned axis_weight(logic [63:0] d2, logic [31:0] iv);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] hi;
        logic [63:0] lo;
        a  = 64'(d2[63:32]) * 64'(iv);
        b  = 64'(d2[31:0]) * 64'(iv);
        hi = a >> 1;
        lo = ((64'(a[0]) << 32) + b) >> 33;
        if (hi >= AXIS_CAP) return AXIS_CAP;
        hi = hi + lo;
        return (hi > AXIS_CAP) ? AXIS_CAP : hi;
    endfunction

    // Advance the mirror by one accepted word; queue the result an observation causes.
    task automatic model_word(t_in_word w);
        t_out_word   r;
        logic [15:0] ang;
        longint      s, c, ox, oy, mapx, mapy, dx, dy, ax, ay, total;
        logic [63:0] dx2, dy2, d, best_d, best_dx2, best_dy2;
        int          best;
        if (!w.kind) begin
            // Drop loads once the table is full.
            if (lm_count < TABLE_DEPTH) begin
                lm_id[lm_count] = w.landmark_id;
                lm_x[lm_count]  = w.pos_x;
                lm_y[lm_count]  = w.pos_y;
                lm_count++;
            end
            return;
        end
        r = '0;
        r.status = 1'b1;
        if (lm_count > 0) begin
            ang  = (w.particle_heading >> ANGLE_DROP) << ANGLE_DROP;
            s    = turn_sine(ang);
            c    = turn_sine(ang + 16'h4000);
            ox   = longint'(w.pos_x);
            oy   = longint'(w.pos_y);
            mapx = clamp32(longint'(w.particle_x) + ((ox * c - oy * s) >>> 30));
            mapy = clamp32(longint'(w.particle_y) + ((ox * s + oy * c) >>> 30));
            best = 0;
            best_d = '0;
            best_dx2 = '0;
            best_dy2 = '0;
            for (int i = 0; i < lm_count; i++) begin
                dx  = mapx - longint'($signed(lm_x[i]));
                dy  = mapy - longint'($signed(lm_y[i]));
                ax  = (dx < 0) ? -dx : dx;
                ay  = (dy < 0) ? -dy : dy;
                dx2 = 64'(ax) * 64'(ax);
                dy2 = 64'(ay) * 64'(ay);
                d   = dx2 + dy2;
                if (d < dx2) d = '1;
                // First minimum wins, so only a strictly smaller distance replaces it.
                if (i == 0 || d < best_d) begin
                    best = i;
                    best_d = d;
                    best_dx2 = dx2;
                    best_dy2 = dy2;
                end
            end
            total = weight_acc + longint'(axis_weight(best_dx2, inv_var_x_reg))
                  + longint'(axis_weight(best_dy2, inv_var_y_reg))
                  + longint'($signed(log_norm_reg));
            if (total > SUM_MAX) total = SUM_MAX;
            if (total < SUM_MIN) total = SUM_MIN;
            weight_acc   = total;
            r.matched_id = lm_id[best];
            r.matched_x  = lm_x[best];
            r.matched_y  = lm_y[best];
            r.status     = 1'b0;
        end
        r.neg_log_weight = weight_acc[47:0];
        r.weight_final   = w.last_observation;
        if (w.last_observation) weight_acc = 0;
        pending_results.insert(pending_results.size(), r);
    endtask

    // ---------------------------------------------------------------
    // Result checker: compare every accepted result word with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word e;
        t_out_word a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, a);
                mismatch_count++;
            end else begin
                e = pending_results.pop_front();
                if (a.matched_id !== e.matched_id) begin
                    $display("%0t: matched_id exp %0d got %0d", $time, e.matched_id,
                             a.matched_id);
                    mismatch_count++;
                end
                if (a.matched_x !== e.matched_x) begin
                    $display("%0t: matched_x exp %0d got %0d", $time, e.matched_x,
                             a.matched_x);
                    mismatch_count++;
                end
                if (a.matched_y !== e.matched_y) begin
                    $display("%0t: matched_y exp %0d got %0d", $time, e.matched_y,
                             a.matched_y);
                    mismatch_count++;
                end
                if (a.neg_log_weight !== e.neg_log_weight) begin
                    $display("%0t: neg_log_weight exp %0d got %0d", $time,
                             e.neg_log_weight, a.neg_log_weight);
                    mismatch_count++;
                end
                if (a.weight_final !== e.weight_final) begin
                    $display("%0t: weight_final exp %0b got %0b", $time, e.weight_final,
                             a.weight_final);
                    mismatch_count++;
                end
                if (a.status !== e.status) begin
                    $display("%0t: status exp %0b got %0b", $time, e.status, a.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Receiver: random ready stretches; serve a long hold-off when one is requested.
    initial begin : receiver
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_served) begin
                hold_served = hold_reqs;
                out_ch.ready <= 1'b0;
                n = LONG_HOLD;
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 8);
            end else begin
                out_ch.ready <= 1'b0;
                n = pick_gap();
            end
            repeat (n - 1) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offer one word, hold it until accepted, then maybe idle.
    task automatic send_word(t_in_word w);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        model_word(w);
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(logic [15:0] id, logic [31:0] x, logic [31:0] y);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.kind = 1'b0;
        w.landmark_id = id;
        w.pos_x = x;
        w.pos_y = y;
        send_word(w);
    endtask

    task automatic send_obs(logic [31:0] ox, logic [31:0] oy, logic [31:0] px,
                            logic [31:0] py, logic [15:0] hdg, logic last);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.kind = 1'b1;
        w.pos_x = ox;
        w.pos_y = oy;
        w.particle_x = px;
        w.particle_y = py;
        w.particle_heading = hdg;
        w.last_observation = last;
        send_word(w);
    endtask

    // Drop valid, wait for every result, then let the back end finish any load.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (lm_count + 40) @(posedge i_clk);
    endtask

    // Keep the write enable up across consecutive writes; the caller drops it.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_INV_VAR_X: inv_var_x_reg = value;
            CFG_INV_VAR_Y: inv_var_y_reg = value;
            CFG_LOG_NORM:  log_norm_reg  = value;
            default: ;
        endcase
    endtask

    task automatic set_weights(logic [31:0] ivx, logic [31:0] ivy, logic [31:0] ln);
        wait_idle();
        write_reg(CFG_INV_VAR_X, ivx);
        write_reg(CFG_INV_VAR_Y, ivy);
        write_reg(CFG_LOG_NORM, ln);
        i_cfg_we <= 1'b0;
    endtask

    // Coordinate within about 64 m of the origin.
    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Observations before any load: status 1, sum still closes.
    task automatic test_empty_table();
        send_obs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
        send_obs(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1);
    endtask

    // Extreme landmarks, a tie, the four quadrants and saturated map positions.
    task automatic test_directed();
        send_load(16'hFFFF, 32'h8000_0000, 32'h8000_0000);
        send_load(16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_load(16'h1234, 32'h0001_0000, 32'h0);
        send_load(16'h4321, 32'h0001_0000, 32'h0);
        send_obs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
        send_obs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'h4000, 1'b0);
        send_obs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0);
        send_obs(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'hC000, 1'b1);
        send_obs(32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0, 16'h003F, 1'b0);
        send_obs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 1'b0);
        send_obs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0);
        send_obs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
    endtask

    // Drive the sum into its upper saturation limit, then down with a negative log norm.
    task automatic test_saturation();
        set_weights(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_obs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 16'h1000, i == 3);
        set_weights(32'h0, 32'h0, 32'h8000_0000);
        for (int i = 0; i < 4; i++)
            send_obs(near_coord(), near_coord(), 32'h0, 32'h0, 16'h0, i == 3);
    endtask

    // Mostly well-formed particle updates near the map, some full-range noise.
    task automatic test_random(int count);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 99) < 85) begin
                w.kind = (lm_count < TABLE_DEPTH && $urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
                w.pos_x = w.kind ? 32'($signed(near_coord()) >>> 1) : near_coord();
                w.pos_y = w.kind ? 32'($signed(near_coord()) >>> 1) : near_coord();
                w.particle_x = near_coord();
                w.particle_y = near_coord();
                w.last_observation = ($urandom_range(0, 3) == 0);
            end
            send_word(w);
        end
    endtask

    // Fill the table and offer extra loads, which must be dropped.
    task automatic test_table_full();
        while (lm_count < TABLE_DEPTH + 0)
            send_load(16'($urandom), near_coord(), near_coord());
        repeat (3) send_load(16'($urandom), 32'h0, 32'h0);
        repeat (4) send_obs(32'h0, 32'h0, 32'h0, 32'h0, 16'($urandom), 1'b0);
    endtask

    // Hold the receiver off while observations keep coming, so the input stalls.
    task automatic test_backpressure();
        quiet = 1'b1;
        hold_reqs++;
        repeat (12) send_obs(near_coord(), near_coord(), near_coord(), near_coord(),
                             16'($urandom), 1'($urandom));
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        mismatch_count = 0;
        quiet = 1'b0;
        hold_reqs = 0;
        hold_served = 0;
        lm_count = 0;
        weight_acc = 0;
        inv_var_x_reg = 32'd65536;
        inv_var_y_reg = 32'd65536;
        log_norm_reg = 32'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed();
        test_saturation();
        set_weights(32'd65536, 32'd65536, 32'd0);
        test_random(140);
        set_weights(32'h0000_0100, 32'h0004_0000, 32'($urandom));
        test_random(140);
        test_table_full();
        set_weights(32'($urandom), 32'($urandom), 32'hFFF0_0000);
        test_backpressure();
        test_random(130);
        set_weights(32'hFFFF_FFFF, 32'h0, 32'h0001_0000);
        test_random(130);

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** landmark_association_weight_top: PASSED **");
        else
            $display("** landmark_association_weight_top: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #8ms;
        $display("** landmark_association_weight_top: FAILED **");
        $finish;
    end

endmodule

### filelist.f
design/law_pkg.sv
design/law_if.sv
design/law_front.sv
design/law_queue.sv
design/law_back.sv
design/landmark_association_weight_top.sv
tb/tb_top.sv
